FILE: rtl/core/stsr_pkg.sv
`default_nettype none

package stsr_pkg;

    localparam int unsigned COUNT_WIDTH_DEF = 16;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned BIT_NUM_W       = 3;

    localparam logic [BYTE_W-1:0]    FRAME_BYTES_RST = 8'd1;
    localparam logic [BIT_NUM_W-1:0] LAST_BIT        = 3'd7;

    // Input operation codes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_READY = 3'd1,
        PH_SYNC  = 3'd2,
        PH_WAIT  = 3'd3,
        PH_RECV  = 3'd4,
        PH_STOP  = 3'd5
    } phase_t;

    typedef struct packed {
        logic              byte_valid;
        logic [BYTE_W-1:0] byte_value;
        logic [BYTE_W-1:0] byte_index;
        logic              frame_done;
        logic              busy_res;
    } rx_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/stsr_fsm.sv
`default_nettype none

module stsr_fsm
    import stsr_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic              operation,
    input  wire logic              line_level,
    input  wire logic [BYTE_W-1:0] frame_bytes,
    output rx_result_t             result
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

    phase_t                 phase_reg, phase_next;
    logic                   prev_line_reg;
    logic [COUNT_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic [COUNT_WIDTH-1:0] bit_period_reg, bit_period_next;
    logic [BYTE_W-1:0]      shift_byte_reg, shift_byte_next;
    logic [BIT_NUM_W-1:0]   bit_number_reg, bit_number_next;
    logic [BYTE_W-1:0]      bytes_rcvd_reg, bytes_rcvd_next;

    logic                   falling;
    logic                   rising;
    logic [COUNT_WIDTH-1:0] timer_target;
    logic                   timer_hit;
    logic                   last_bit;
    logic                   frame_complete;
    logic [BYTE_W-1:0]      shift_in;

    assign falling        = prev_line_reg & ~line_level;
    assign rising         = ~prev_line_reg & line_level;
    // The post-sync wait lasts half a period; bit and stop waits a full one.
    assign timer_target   = (phase_reg == PH_WAIT) ? (bit_period_reg >> 1) : bit_period_reg;
    assign timer_hit      = (tick_count_reg >= timer_target);
    assign last_bit       = (bit_number_reg == LAST_BIT);
    assign frame_complete = (bytes_rcvd_reg >= frame_bytes);
    assign shift_in       = shift_byte_reg | {{(BYTE_W-1){1'b0}}, ~line_level};

    always_comb begin
        phase_next = phase_reg;
        if (operation == OP_START) begin
            phase_next = PH_READY;
        end else begin
            case (phase_reg)
                PH_IDLE:  phase_next = PH_IDLE;
                PH_READY: if (falling) phase_next = PH_SYNC;
                PH_SYNC:  if (rising) phase_next = PH_WAIT;
                PH_WAIT:  if (timer_hit) phase_next = PH_RECV;
                PH_RECV:  if (timer_hit && last_bit) phase_next = PH_STOP;
                PH_STOP: begin
                    if (timer_hit) begin
                        phase_next = frame_complete ? PH_IDLE : PH_READY;
                    end
                end
                default:  phase_next = PH_IDLE;
            endcase
        end
    end

    always_comb begin
        tick_count_next   = tick_count_reg;
        bit_period_next   = bit_period_reg;
        shift_byte_next   = shift_byte_reg;
        bit_number_next   = bit_number_reg;
        bytes_rcvd_next   = bytes_rcvd_reg;
        result            = '0;
        if (operation == OP_START) begin
            tick_count_next = '0;
            shift_byte_next = '0;
            bit_number_next = '0;
            bytes_rcvd_next = '0;
        end else begin
            case (phase_reg)
                PH_READY: begin
                    if (falling) tick_count_next = '0;
                end
                PH_SYNC: begin
                    if (rising) begin
                        bit_period_next = tick_count_reg;
                        tick_count_next = '0;
                    end else if (tick_count_reg != COUNT_MAX) begin
                        tick_count_next = tick_count_reg + COUNT_ONE;
                    end
                end
                PH_WAIT: begin
                    tick_count_next = timer_hit ? '0 : tick_count_reg + COUNT_ONE;
                end
                PH_RECV: begin
                    tick_count_next = timer_hit ? '0 : tick_count_reg + COUNT_ONE;
                    if (timer_hit) begin
                        if (last_bit) begin
                            result.byte_valid = 1'b1;
                            result.byte_value = shift_in;
                            result.byte_index = frame_bytes - FRAME_BYTES_RST - bytes_rcvd_reg;
                            bytes_rcvd_next   = bytes_rcvd_reg + BYTE_W'(1);
                            shift_byte_next   = '0;
                            bit_number_next   = '0;
                        end else begin
                            shift_byte_next = {shift_in[BYTE_W-2:0], 1'b0};
                            bit_number_next = bit_number_reg + BIT_NUM_W'(1);
                        end
                    end
                end
                PH_STOP: begin
                    tick_count_next = timer_hit ? '0 : tick_count_reg + COUNT_ONE;
                    if (timer_hit && frame_complete) begin
                        result.frame_done = 1'b1;
                        tick_count_next   = '0;
                        shift_byte_next   = '0;
                        bit_number_next   = '0;
                        bytes_rcvd_next   = '0;
                    end
                end
                default: begin
                end
            endcase
        end
        result.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            prev_line_reg  <= 1'b1;
            tick_count_reg <= '0;
            bit_period_reg <= '0;
            shift_byte_reg <= '0;
            bit_number_reg <= '0;
            bytes_rcvd_reg <= '0;
        end else if (step) begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_period_reg <= bit_period_next;
            shift_byte_reg <= shift_byte_next;
            bit_number_reg <= bit_number_next;
            bytes_rcvd_reg <= bytes_rcvd_next;
            // A start transaction carries no line sample.
            if (operation == OP_TICK) begin
                prev_line_reg <= line_level;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/self_timed_serial_receiver_top.sv
// A result is registered and appears on the m_ channel in the cycle after its input transaction.
// Throughput: one input transaction per cycle; the receive state advances on each one.
// A result waiting on m_ready stalls input; taking it frees it that cycle, no bubbles.
// Reset (aresetn low, synchronous): receiver idle, line assumed high, counters cleared,
// frame_bytes set to 1, no result pending.
`default_nettype none

module self_timed_serial_receiver_top
    import stsr_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output wire logic              cfg_ready,
    input  wire logic [BYTE_W-1:0] cfg_data,
    input  wire logic              s_valid,
    output wire logic              s_ready,
    input  wire logic              s_operation,
    input  wire logic              s_line_level,
    output wire logic              m_valid,
    input  wire logic              m_ready,
    output wire logic              m_byte_valid,
    output wire logic [BYTE_W-1:0] m_byte_value,
    output wire logic [BYTE_W-1:0] m_byte_index,
    output wire logic              m_frame_done,
    output wire logic              m_busy_res
);

    logic [BYTE_W-1:0] frame_bytes_reg;
    logic              m_valid_reg;
    rx_result_t        result;
    rx_result_t        result_reg;
    logic              step;

    assign cfg_ready = 1'b1;
    assign s_ready   = ~m_valid_reg | m_ready;
    assign step      = s_valid & s_ready;

    stsr_fsm #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .operation   (s_operation),
        .line_level  (s_line_level),
        .frame_bytes (frame_bytes_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_bytes_reg <= FRAME_BYTES_RST;
        end else if (cfg_valid) begin
            frame_bytes_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            result_reg <= result;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_byte_valid = result_reg.byte_valid;
    assign m_byte_value = result_reg.byte_value;
    assign m_byte_index = result_reg.byte_index;
    assign m_frame_done = result_reg.frame_done;
    assign m_busy_res   = result_reg.busy_res;

endmodule

`default_nettype wire
